### design/gta_pkg.sv
// Package for the tanh-approximated GeLU pipeline.
// Holds fixed-point widths, Q16 constants and the 2^(-k/16) table.
// No dependencies.
package gta_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 10;

    localparam int ZQ_W     = 19;
    localparam int ZQ_SHIFT = 16 - FRAC_BITS;
    localparam int NSTAGE   = 24;

    localparam logic [DATA_WIDTH-1:0] BIG_MAG = DATA_WIDTH'(8 << FRAC_BITS);

    localparam logic [16:0] C1Q  = 17'd104580;
    localparam logic [12:0] C3Q  = 13'd4676;
    localparam logic [16:0] L2EQ = 17'd94548;
    localparam logic [16:0] ONEQ = 17'd65536;
    localparam logic [7:0]  N_MAX = 8'd17;

    typedef struct packed {
        logic                  neg;
        logic [DATA_WIDTH-1:0] mag;
        logic                  last;
        logic                  zero;
    } t_side;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] sample;
        logic                         last;
    } t_res;

    function automatic logic [16:0] pow2_neg(input logic [4:0] idx);
        logic [16:0] v;
        case (idx)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

endpackage

### design/gta_if.sv
// Valid/ready stream interfaces for GeLU input and result beats.
// Depends on gta_pkg for the sample width.
interface gta_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [gta_pkg::DATA_WIDTH-1:0]  sample_in;
    logic                                   last_in;
    modport source (output valid, output sample_in, output last_in, input ready);
    modport sink   (input valid, input sample_in, input last_in, output ready);
endinterface

interface gta_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [gta_pkg::DATA_WIDTH-1:0]  sample_out;
    logic                                   last_out;
    modport source (output valid, output sample_out, output last_out, input ready);
    modport sink   (input valid, input sample_out, input last_out, output ready);
endinterface

### design/gelu_tanh_activation_top.sv
// GeLU (tanh form) pipeline: 24 register stages, then a skid entry and output register.
// All stages hold while the skid entry is full; stage 24 feeds the skid entry and output register.
// Throughput: one beat per cycle while the skid entry is empty; 16 stages are a restoring divider.
// Reset clears all valid bits and the skid/output flags; payload is not reset.
// Depends on gta_pkg and gta_if.
module gelu_tanh_activation_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gta_in_if.sink    i_in,
    gta_out_if.source o_out
);
    import gta_pkg::*;

    logic                 en;
    logic [NSTAGE:1]      r_v;
    t_side                r_side [1:NSTAGE-1];

    logic [ZQ_W-1:0]      r1_zq, r2_zq, r3_zq;
    logic [21:0]          r2_z2;
    logic [19:0]          r3_g;
    logic [22:0]          r4_u;
    logic [4:0]           r5_n, r6_n;
    logic [3:0]           r5_i;
    logic [11:0]          r5_r;
    logic [16:0]          r6_m;

    logic [16:0]          r_rem [7:23];
    logic [15:0]          r_nlo [7:23];
    logic [17:0]          r_den [7:23];
    logic [15:0]          r_q   [7:23];

    t_res                 r_res, r_skid, r_out;
    logic                 r_skid_v, r_ov;

    // stage combinational values
    logic [DATA_WIDTH-1:0] n1_a;
    logic                  n1_neg;
    logic [37:0]           n2_p;
    logic [34:0]           n3_p;
    logic [38:0]           n4_p;
    logic [39:0]           n5_t;
    logic [16:0]           n6_ti, n6_ti1;
    logic [11:0]           n6_d;
    logic [24:0]           n6_p;
    logic [16:0]           n7_e;
    logic [17:0]           n7_den;
    logic [33:0]           n7_num;
    logic [15:0]           n24_q;
    logic [16:0]           n24_s;
    logic [33:0]           n24_p;
    logic [15:0]           n24_mag;
    t_res                  n_res;

    assign en         = !r_skid_v;
    assign i_in.ready = en;

    assign n1_neg = i_in.sample_in[DATA_WIDTH-1];
    assign n1_a   = n1_neg ? DATA_WIDTH'(0 - i_in.sample_in) : DATA_WIDTH'(i_in.sample_in);
    assign n2_p   = 38'(r1_zq) * 38'(r1_zq);
    assign n3_p   = 35'(C3Q) * 35'(r2_z2);
    assign n4_p   = 39'(r3_zq) * 39'(r3_g);
    assign n5_t   = 40'(r4_u) * 40'(L2EQ);
    assign n6_ti  = pow2_neg({1'b0, r5_i});
    assign n6_ti1 = pow2_neg(5'({1'b0, r5_i}) + 5'd1);
    assign n6_d   = 12'(n6_ti - n6_ti1);
    assign n6_p   = 25'(n6_d) * 25'(r5_r) + 25'd2048;
    assign n7_e   = r6_m >> r6_n;
    assign n7_den = 18'(ONEQ) + 18'(n7_e);
    assign n7_num = {1'b0, n7_e, 16'd0} + 34'(n7_den >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NSTAGE-1:1], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[1] <= '{neg: n1_neg, mag: n1_a, last: i_in.last_in,
                           zero: (n1_a >= BIG_MAG)};
            for (int k = 2; k <= NSTAGE-1; k++) begin
                if (k != 5) begin
                    r_side[k] <= r_side[k-1];
                end
            end
            r_side[5] <= '{neg: r_side[4].neg, mag: r_side[4].mag, last: r_side[4].last,
                           zero: r_side[4].zero | (n5_t[39:32] >= N_MAX)};

            r1_zq <= ZQ_W'(n1_a) << ZQ_SHIFT;
            r2_zq <= r1_zq;
            r2_z2 <= n2_p[37:16];
            r3_zq <= r2_zq;
            r3_g  <= 20'(C1Q) + 20'(n3_p[34:16]);
            r4_u  <= n4_p[38:16];
            r5_n  <= n5_t[36:32];
            r5_i  <= n5_t[31:28];
            r5_r  <= n5_t[27:16];
            r6_n  <= r5_n;
            r6_m  <= n6_ti - 17'(n6_p[24:12]);

            r_rem[7] <= n7_num[32:16];
            r_nlo[7] <= n7_num[15:0];
            r_den[7] <= n7_den;
            r_q[7]   <= '0;
        end
    end

    for (genvar k = 8; k <= 23; k++) begin : g_div
        logic [17:0] n_sh;
        logic [18:0] n_diff;
        assign n_sh   = {r_rem[k-1], r_nlo[k-1][23-k]};
        assign n_diff = {1'b0, n_sh} - {1'b0, r_den[k-1]};
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rem[k] <= n_diff[18] ? n_sh[16:0] : n_diff[16:0];
                r_nlo[k] <= r_nlo[k-1];
                r_den[k] <= r_den[k-1];
                r_q[k]   <= {r_q[k-1][14:0], !n_diff[18]};
            end
        end
    end

    assign n24_q   = r_side[23].zero ? '0 : r_q[23];
    assign n24_s   = (!r_side[23].neg && (r_side[23].mag != '0)) ?
                     (ONEQ - 17'(n24_q)) : 17'(n24_q);
    assign n24_p   = 34'(r_side[23].mag) * 34'(n24_s) + 34'd32768;
    assign n24_mag = n24_p[31:16];
    assign n_res   = '{sample: r_side[23].neg ? DATA_WIDTH'(0 - n24_mag) : n24_mag,
                       last: r_side[23].last};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res <= n_res;
        end
    end

    // output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov     <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_ov || o_out.ready) begin
            if (r_skid_v) begin
                r_out    <= r_skid;
                r_ov     <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out <= r_res;
                r_ov  <= r_v[NSTAGE];
            end
        end else if (r_v[NSTAGE] && en) begin
            r_skid   <= r_res;
            r_skid_v <= 1'b1;
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.sample_out = r_out.sample;
    assign o_out.last_out   = r_out.last;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_ov)
        else $error("skid entry held without a result on the output");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v && !o_out.ready |=> r_skid_v && $stable(r_skid))
        else $error("skid entry dropped while output stalled");

    a_pipe_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |=> $stable(r_v))
        else $error("pipeline advanced while skid entry full");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v && o_out.ready |=> r_ov && !r_skid_v)
        else $error("skid entry not moved to output after beat");

endmodule

### dv/gelu_tanh_activation_top_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the tanh-form GeLU pipeline: directed, random and output-stall beats,
// with random idling on both sides, checked against an integer predictor.
// Depends on gta_pkg, gta_if and gelu_tanh_activation_top.
module gelu_tanh_activation_top_tb;
    import gta_pkg::*;

    logic i_clk;
    logic i_rst_n;

    gta_in_if  in_bus ();
    gta_out_if out_bus ();

    gelu_tanh_activation_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus.sink),
        .o_out   (out_bus.source)
    );

    t_res gelu_expected_q[$];
    int   mismatch_cnt;
    int   beats_sent;
    int   beats_checked;
    bit   sink_idle_en;
    bit   sink_hold;
    bit   src_idle_en;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [63:0] inv_one_plus_exp(input logic [63:0] a);
        logic [63:0] tab [0:16];
        logic [63:0] zq, z2, g, u, t, n, f, k, r, m, e;
        tab = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
                46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};
        if (a >= (64'd8 << FRAC_BITS)) return 64'd0;
        zq = (a << 16) >> FRAC_BITS;
        z2 = (zq * zq) >> 16;
        g  = 64'd104580 + ((64'd4676 * z2) >> 16);
        u  = (zq * g) >> 16;
        t  = (u * 64'd94548) >> 16;
        n  = t >> 16;
        if (n >= 17) return 64'd0;
        f  = t & 64'hFFFF;
        k  = f >> 12;
        r  = f & 64'hFFF;
        m  = tab[k] - (((tab[k] - tab[k+1]) * r + 64'd2048) >> 12);
        e  = m >> n;
        return (e * 64'd65536 + ((64'd65536 + e) >> 1)) / (64'd65536 + e);
    endfunction

    function automatic t_res gelu_predict(input logic [DATA_WIDTH-1:0] z, input logic lst);
        t_res        res;
        logic        neg;
        logic [63:0] a, q, s, mag;
        neg = z[DATA_WIDTH-1];
        a   = neg ? ((64'd1 << DATA_WIDTH) - {48'd0, z}) : {48'd0, z};
        q   = inv_one_plus_exp(a);
        s   = (!neg && a != 0) ? (64'd65536 - q) : q;
        mag = (a * s + 64'd32768) >> 16;
        res.sample = neg ? DATA_WIDTH'(-mag) : DATA_WIDTH'(mag);
        res.last   = lst;
        return res;
    endfunction

    task automatic send_beat(input logic [DATA_WIDTH-1:0] z, input logic lst);
        int gap;
        if (src_idle_en && ($urandom_range(0, 5) == 0)) begin
            gap = $urandom_range(1, 17);
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_bus.valid     <= 1'b1;
        in_bus.sample_in <= z;
        in_bus.last_in   <= lst;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        gelu_expected_q.push_back(gelu_predict(z, lst));
        beats_sent++;
    endtask

    task automatic go_idle();
        in_bus.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_res exp_res;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (gelu_expected_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result beat %0d", out_bus.sample_out);
            end else begin
                exp_res = gelu_expected_q.pop_front();
                if (out_bus.sample_out !== exp_res.sample || out_bus.last_out !== exp_res.last)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: expected %0d/%0b, got %0d/%0b",
                                 exp_res.sample, exp_res.last,
                                 out_bus.sample_out, out_bus.last_out);
                end
                beats_checked++;
            end
        end
    end

    initial begin
        int cnt;
        out_bus.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (sink_hold) begin
                out_bus.ready <= 1'b0;
                @(posedge i_clk);
            end else if (sink_idle_en && ($urandom_range(0, 5) == 0)) begin
                cnt = $urandom_range(1, 17);
                out_bus.ready <= 1'b0;
                repeat (cnt) @(posedge i_clk);
            end else begin
                out_bus.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic drain_results();
        while (gelu_expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        logic [DATA_WIDTH-1:0] pts [$];
        pts = '{16'h0000, 16'h7FFF, 16'h8000, 16'h8001, 16'hFFFF, 16'h0001,
                16'h2000, 16'hE000, 16'h1FFF, 16'hE001, 16'h0400, 16'hFC00,
                16'h0800, 16'hF800, 16'h0C00, 16'hF400, 16'h1800, 16'hE800,
                16'h5555, 16'hAAAA, 16'h0100, 16'hFF00};
        foreach (pts[k]) send_beat(pts[k], k[0]);
        go_idle();
        drain_results();
    endtask

    task automatic test_random(input int count);
        logic [DATA_WIDTH-1:0] z;
        repeat (count) begin
            if ($urandom_range(0, 3) != 0)
                z = DATA_WIDTH'($signed($urandom_range(0, 18432)) - 9216);
            else
                z = DATA_WIDTH'($urandom);
            send_beat(z, ($urandom_range(0, 7) == 0));
        end
    endtask

    task automatic test_backpressure();
        int held;
        sink_hold = 1'b1;
        fork
            begin
                held = 0;
                while (held < 120) begin
                    @(posedge i_clk);
                    held++;
                end
                sink_hold = 1'b0;
            end
            test_random(80);
        join
        go_idle();
        drain_results();
    endtask

    initial begin
        mismatch_cnt  = 0;
        beats_sent    = 0;
        beats_checked = 0;
        sink_idle_en  = 1'b0;
        sink_hold     = 1'b0;
        src_idle_en   = 1'b0;
        i_rst_n          <= 1'b0;
        in_bus.valid     <= 1'b0;
        in_bus.sample_in <= '0;
        in_bus.last_in   <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        sink_idle_en = 1'b1;
        src_idle_en  = 1'b1;
        test_random(900);
        go_idle();
        drain_results();
        test_backpressure();
        sink_idle_en = 1'b0;
        src_idle_en  = 1'b0;
        test_random(400);
        go_idle();

        cnt_wait: begin
            int lim;
            lim = 0;
            while (gelu_expected_q.size() != 0 && lim < 100000) begin
                @(posedge i_clk);
                lim++;
            end
        end
        repeat (40) @(posedge i_clk);

        $display("Sent %0d beats (directed edges, random, long output stall); checked %0d.",
                 beats_sent, beats_checked);
        if (mismatch_cnt == 0 && gelu_expected_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatch_cnt,
                     gelu_expected_q.size());
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

### sim.f
design/gta_pkg.sv
design/gta_if.sv
design/gelu_tanh_activation_top.sv
dv/gelu_tanh_activation_top_tb.sv
